// ===== rtl/edd_pkg.sv =====
`default_nettype none

package edd_pkg;

  // Defaults for the top-level parameters
  localparam int EDD_MAX_WIDTH_DEF = 1024;
  localparam int EDD_FRAC_BITS_DEF = 12;

  // Frame height limit and row counter width
  localparam int EDD_MAX_HEIGHT = 1024;
  localparam int EDD_ROW_W      = $clog2(EDD_MAX_HEIGHT);

  // Configuration port
  localparam int EDD_CFG_W = 11;
  localparam logic [EDD_CFG_W-1:0] EDD_WIDTH_RST  = 11'd640;
  localparam logic [EDD_CFG_W-1:0] EDD_HEIGHT_RST = 11'd480;

  typedef enum logic [0:0] {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } edd_reg_t;

  // Diffusion weights, all over 16
  localparam logic [2:0] W_UL   = 3'd1;
  localparam logic [2:0] W_UP   = 3'd5;
  localparam logic [2:0] W_UR   = 3'd3;
  localparam logic [2:0] W_LEFT = 3'd7;

  // Which neighbors take part for one pixel
  typedef struct packed {
    logic y_nz;    // not on the first row
    logic x_nz;    // not in the first column
    logic has_ur;  // upper-right neighbor exists
  } edd_nbr_t;

endpackage

`default_nettype wire

// ===== rtl/edd_stream_if.sv =====
`default_nettype none

interface edd_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source (output valid, red_in, green_in, blue_in, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, output ready);
endinterface

interface edd_res_if;
  logic valid;
  logic ready;
  logic red_bit;
  logic green_bit;
  logic blue_bit;
  logic frame_end;

  modport source (output valid, red_bit, green_bit, blue_bit, frame_end, input ready);
  modport sink   (input valid, red_bit, green_bit, blue_bit, frame_end, output ready);
endinterface

`default_nettype wire

// ===== rtl/edd_chan.sv =====
`default_nettype none

module edd_chan #(
  parameter int FRAC_BITS = edd_pkg::EDD_FRAC_BITS_DEF
) (
  // first stage: upper neighbors
  input  logic [7:0]               pix,
  input  edd_pkg::edd_nbr_t        nbr,
  input  logic signed [FRAC_BITS:0] ul,
  input  logic signed [FRAC_BITS:0] up,
  input  logic signed [FRAC_BITS:0] ur,
  output logic [FRAC_BITS:0]       part,
  // second stage: left neighbor, threshold
  input  logic [FRAC_BITS:0]       part_in,
  input  logic                     left_en,
  input  logic signed [FRAC_BITS:0] left,
  output logic                     bit_o,
  output logic signed [FRAC_BITS:0] err
);
  import edd_pkg::*;

  localparam int VW = FRAC_BITS + 1;
  localparam int PW = FRAC_BITS + 5;
  localparam logic [VW-1:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [VW-1:0] HALF = ONE >> 1;

  // error * w / 16, rounded to nearest with ties toward plus infinity
  function automatic logic signed [VW-1:0] weigh(input logic signed [VW-1:0] e,
                                                 input logic [2:0] w);
    logic signed [PW-1:0] p;
    p = PW'(e) * $signed(PW'(w));
    p = p + PW'(8);
    return VW'(p >>> 4);
  endfunction

  function automatic logic [VW-1:0] add_clamp(input logic [VW-1:0] v,
                                              input logic signed [VW-1:0] d);
    logic signed [VW+1:0] s;
    s = $signed({2'b00, v}) + (VW+2)'(d);
    if (s < 0) begin
      return '0;
    end else if (s > $signed({2'b00, ONE})) begin
      return ONE;
    end
    return VW'(s);
  endfunction

  logic [VW-1:0] v_base, v_ul, v_up, v_fin;
  logic signed [VW:0] diff;

  always_comb begin
    v_base = VW'(pix) << (FRAC_BITS - 8);
    v_ul   = (nbr.y_nz && nbr.x_nz) ? add_clamp(v_base, weigh(ul, W_UL)) : v_base;
    v_up   = nbr.y_nz ? add_clamp(v_ul, weigh(up, W_UP)) : v_ul;
    part   = nbr.has_ur ? add_clamp(v_up, weigh(ur, W_UR)) : v_up;
  end

  always_comb begin
    v_fin = left_en ? add_clamp(part_in, weigh(left, W_LEFT)) : part_in;
    bit_o = (v_fin > HALF);
    diff  = $signed({1'b0, v_fin}) - $signed({1'b0, (bit_o ? ONE : '0)});
    err   = $signed(diff[VW-1:0]);
  end

endmodule

`default_nettype wire

// ===== rtl/error_diffusion_dither_core.sv =====
`default_nettype none

// Channel   Dir  Words             Payload
// in_pix    in   one RGB pixel     red_in, green_in, blue_in (8 bits each)
// out_res   out  one binary pixel  red_bit, green_bit, blue_bit, frame_end
// cfg_*     in   register write    cfg_idx selects width or height, 11-bit data
//
// One pixel per cycle sustained while the output accepts; a pixel taken passes
// through stage A, stage B and the output register. The previous row's errors
// sit in one row memory (one read, one write per cycle). Below the first row,
// the first pixel of a row waits in the first stage for the write of the pixel
// ahead when the frame is one or two pixels wide, so such narrow frames run
// below the full rate. Synchronous active-low reset clears counters and
// pipeline valids; the row memory needs no clearing pass. A stalled output
// holds the pipeline and backs up the input through a combinational ready.

module error_diffusion_dither_core #(
  parameter int MAX_WIDTH = edd_pkg::EDD_MAX_WIDTH_DEF,
  parameter int FRAC_BITS = edd_pkg::EDD_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  edd_pkg::edd_reg_t                cfg_idx,
  input  logic [edd_pkg::EDD_CFG_W-1:0]    cfg_data,
  edd_pix_if.sink                          in_pix,
  edd_res_if.source                        out_res
);
  import edd_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int XW = (CW + 1 > EDD_CFG_W) ? CW + 1 : EDD_CFG_W;
  localparam int EW = FRAC_BITS + 1;   // signed error / unsigned value width
  localparam int MW = 3 * EW;          // row memory word

  // ---------------------------------------------------------------- config
  logic [EDD_CFG_W-1:0] width_r, height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= EDD_WIDTH_RST;
      height_r <= EDD_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_WIDTH:  width_r  <= cfg_data;
        REG_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------ handshake
  logic a_valid_r, b_valid_r, out_valid_r;
  logic accept, a_fire, b_fire, haz_ur, haz_c0;

  // Stage B registers and results
  logic [EW-1:0]        b_part_r [3];
  logic                 b_x_nz_r;
  logic [CW-1:0]        b_xi_r;
  logic                 b_fend_r;
  logic signed [EW-1:0] left_r [3];
  logic signed [EW-1:0] err_s [3];
  logic                 bit_s [3];

  // ----------------------------------------------------- raster position
  logic [CW-1:0]        col_r;
  logic [EDD_ROW_W-1:0] row_r;
  logic [XW-1:0]        x_inc;
  logic [EDD_CFG_W-1:0] y_inc;
  logic                 last_col, last_row, has_ur;

  always_comb begin
    x_inc    = XW'(col_r) + XW'(1);
    y_inc    = EDD_CFG_W'(row_r) + EDD_CFG_W'(1);
    // out-of-range width or height saturates into 1..max
    last_col = (x_inc >= XW'(width_r)) || (x_inc >= XW'(MAX_WIDTH));
    last_row = (y_inc >= height_r) || (y_inc >= EDD_CFG_W'(EDD_MAX_HEIGHT));
    has_ur   = (row_r != '0) && !last_col;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      if (last_col) begin
        col_r <= '0;
        row_r <= last_row ? '0 : EDD_ROW_W'(y_inc);
      end else begin
        col_r <= CW'(x_inc);
      end
    end
  end

  // ------------------------------------------------------------ row memory
  // Entry x holds the errors of column x from the row above, red lowest.
  logic [MW-1:0] row_mem [MAX_WIDTH];
  logic [MW-1:0] mem_q;
  logic [MW-1:0] wr_word;
  logic [CW-1:0] rd_addr;

  assign rd_addr = CW'(x_inc);

  always_ff @(posedge clk) begin
    if (b_fire) begin
      row_mem[b_xi_r] <= wr_word;
    end
    if (accept) begin
      mem_q <= row_mem[rd_addr];
    end
  end

  // ------------------------------------------------------------ stage A
  // Memory data arrives here; add upper-left, above and upper-right.
  logic [7:0]               a_pix_r [3];
  edd_nbr_t                 a_nbr_r;
  logic [CW-1:0]            a_addr_r, a_xi_r;
  logic                     a_fend_r;
  // Write-to-read bypass for the upper-right entry
  logic                     ovr_r;
  logic [MW-1:0]            ovr_data_r;
  logic [MW-1:0]            ur_word;

  // Errors of the row above for the next pixel, and of column zero
  logic signed [EW-1:0] uw0_r [3], uw1_r [3], col0_r [3];
  logic signed [EW-1:0] ul_s [3], up_s [3], ur_s [3];
  logic [EW-1:0]        part_s [3];

  assign ur_word = ovr_r ? ovr_data_r : mem_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ul_s[c] = uw0_r[c];
      up_s[c] = !a_nbr_r.y_nz ? '0 : (a_nbr_r.x_nz ? uw1_r[c] : col0_r[c]);
      ur_s[c] = a_nbr_r.has_ur ? $signed(ur_word[c*EW +: EW]) : '0;
    end
  end

  // Hold A while B still owes a row-memory entry that A reads.
  assign haz_ur = a_valid_r && a_nbr_r.has_ur && b_valid_r && (b_xi_r == a_addr_r);
  assign haz_c0 = a_valid_r && a_nbr_r.y_nz && !a_nbr_r.x_nz && b_valid_r &&
                  (b_xi_r == '0);

  assign b_fire = b_valid_r && (!out_valid_r || out_res.ready);
  assign a_fire = a_valid_r && !haz_ur && !haz_c0 && (!b_valid_r || b_fire);
  assign in_pix.ready = !a_valid_r || a_fire;
  assign accept = in_pix.valid && in_pix.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      ovr_r     <= 1'b0;
    end else begin
      if (accept) begin
        a_valid_r <= 1'b1;
      end else if (a_fire) begin
        a_valid_r <= 1'b0;
      end
      // catch a write that lands on the entry A is reading
      if (accept) begin
        ovr_r <= b_fire && (b_xi_r == rd_addr);
      end else if (a_valid_r && b_fire && (b_xi_r == a_addr_r)) begin
        ovr_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_pix_r[0]     <= in_pix.red_in;
      a_pix_r[1]     <= in_pix.green_in;
      a_pix_r[2]     <= in_pix.blue_in;
      a_nbr_r.y_nz   <= (row_r != '0);
      a_nbr_r.x_nz   <= (col_r != '0);
      a_nbr_r.has_ur <= has_ur;
      a_addr_r       <= rd_addr;
      a_xi_r         <= col_r;
      a_fend_r       <= last_col && last_row;
    end
    if (accept || (a_valid_r && b_fire && (b_xi_r == a_addr_r))) begin
      ovr_data_r <= wr_word;
    end
  end

  // advance the upper window as each pixel leaves A
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < 3; c++) begin
        uw0_r[c]  <= '0;
        uw1_r[c]  <= '0;
        col0_r[c] <= '0;
      end
    end else begin
      if (a_fire) begin
        for (int c = 0; c < 3; c++) begin
          uw0_r[c] <= up_s[c];
          uw1_r[c] <= ur_s[c];
        end
      end
      if (b_fire && (b_xi_r == '0)) begin
        for (int c = 0; c < 3; c++) begin
          col0_r[c] <= err_s[c];
        end
      end
    end
  end

  // ------------------------------------------------------------ stage B
  // Add the left neighbor, threshold, write the errors back.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      wr_word[c*EW +: EW] = err_s[c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (a_fire) begin
      b_valid_r <= 1'b1;
    end else if (b_fire) begin
      b_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire) begin
      for (int c = 0; c < 3; c++) begin
        b_part_r[c] <= part_s[c];
      end
      b_x_nz_r <= a_nbr_r.x_nz;
      b_xi_r   <= a_xi_r;
      b_fend_r <= a_fend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < 3; c++) begin
        left_r[c] <= '0;
      end
    end else if (b_fire) begin
      for (int c = 0; c < 3; c++) begin
        left_r[c] <= err_s[c];
      end
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_chan
    edd_chan #(
      .FRAC_BITS (FRAC_BITS)
    ) u_chan (
      .pix     (a_pix_r[c]),
      .nbr     (a_nbr_r),
      .ul      (ul_s[c]),
      .up      (up_s[c]),
      .ur      (ur_s[c]),
      .part    (part_s[c]),
      .part_in (b_part_r[c]),
      .left_en (b_x_nz_r),
      .left    (left_r[c]),
      .bit_o   (bit_s[c]),
      .err     (err_s[c])
    );
  end

  // ------------------------------------------------------------ output
  logic out_red_r, out_green_r, out_blue_r, out_fend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (b_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire) begin
      out_red_r   <= bit_s[0];
      out_green_r <= bit_s[1];
      out_blue_r  <= bit_s[2];
      out_fend_r  <= b_fend_r;
    end
  end

  assign out_res.valid     = out_valid_r;
  assign out_res.red_bit   = out_red_r;
  assign out_res.green_bit = out_green_r;
  assign out_res.blue_bit  = out_blue_r;
  assign out_res.frame_end = out_fend_r;

endmodule

`default_nettype wire
